@@ sv/krs_pkg.sv @@
// ----------------------------------------------------------------------------
// krs_pkg
// Shared types and helpers for the keyed record sorter: the record layout,
// the cell control group, the controller states and the float key mapping.
// ----------------------------------------------------------------------------
package krs_pkg;

	localparam int unsigned FieldW = 32;

	typedef struct packed {
		logic [FieldW-1:0] key;
		logic [FieldW-1:0] y;
		logic [FieldW-1:0] z;
		logic [FieldW-1:0] id;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctl_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// Maps a float bit pattern onto an unsigned integer of the same order.
	// Negative zero is folded onto positive zero.
	function automatic logic [FieldW-1:0] order_key(input logic [FieldW-1:0] bits);
		logic [FieldW-1:0] b;
		b = (bits == {1'b1, {(FieldW-1){1'b0}}}) ? '0 : bits;
		if (b[FieldW-1]) begin
			return ~b;
		end
		return b | {1'b1, {(FieldW-1){1'b0}}};
	endfunction

endpackage

@@ sv/krs_cell.sv @@
// ----------------------------------------------------------------------------
// krs_cell
// One slot of the sorting chain. On insert it keeps its record, takes its
// left neighbor's record or takes the new record; on drain it takes its
// right neighbor's record.
// ----------------------------------------------------------------------------
module krs_cell (
	input  logic                       clk,
	input  krs_pkg::cell_ctl_t         ctl,
	input  logic                       occupied,
	input  krs_pkg::rec_t              new_rec,
	input  logic [krs_pkg::FieldW-1:0] new_ok,
	input  logic                       left_gt,
	input  krs_pkg::rec_t              left_rec,
	input  krs_pkg::rec_t              right_rec,
	output logic                       gt,
	output krs_pkg::rec_t              rec
);
	import krs_pkg::*;

	rec_t rec_q;

	// An empty slot sorts above every key, so new records fill from the left.
	assign gt = !occupied || (order_key(rec_q.key) > new_ok);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			rec_q <= right_rec;
		end else if (ctl.ins && gt) begin
			rec_q <= left_gt ? left_rec : new_rec;
		end
	end

endmodule

@@ sv/keyed_record_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_record_sorter_unit
// Collects a run of records and emits them sorted ascending by float key.
// ----------------------------------------------------------------------------
// The input channel takes one record per beat (key_x, coord_y, coord_z,
// record_id, last_item). Every beat that finds room is inserted at once
// into a chain of CAPACITY cells that always stays sorted; equal keys keep
// arrival order. While filling, one beat is accepted every cycle.
// A beat with last_item set ends the run. In the cycle after it is accepted the
// output channel shows the smallest record, and the chain then shifts one
// record toward the output per cycle while out_stall is low. out_last marks
// the final record, and overflow is high on every record of a run in which
// beats arrived at a full chain and were dropped.
// During the drain in_stall is high; the input accepts again in the cycle
// after the final output beat is taken.
// When the receiver raises out_stall the chain holds and the output record
// stays unchanged. Reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module keyed_record_sorter_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [krs_pkg::FieldW-1:0] key_x,
	input  logic [krs_pkg::FieldW-1:0] coord_y,
	input  logic [krs_pkg::FieldW-1:0] coord_z,
	input  logic [krs_pkg::FieldW-1:0] record_id,
	input  logic                       last_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [krs_pkg::FieldW-1:0] out_key_x,
	output logic [krs_pkg::FieldW-1:0] out_coord_y,
	output logic [krs_pkg::FieldW-1:0] out_coord_z,
	output logic [krs_pkg::FieldW-1:0] out_record_id,
	output logic                       out_last,
	output logic                       overflow
);
	import krs_pkg::*;

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	state_t            state_q, state_d;
	logic [CntW-1:0]   fill_q;
	logic              dropped_q;
	logic              in_beat, out_beat, full;
	cell_ctl_t         ctl;
	rec_t              new_rec;
	logic [FieldW-1:0] new_ok;
	logic [CAPACITY-1:0] gt;
	rec_t              recs [CAPACITY];

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;
	assign full     = (fill_q == CntW'(CAPACITY));
	assign new_rec  = '{key: key_x, y: coord_y, z: coord_z, id: record_id};
	assign new_ok   = order_key(key_x);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (in_beat && last_item) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_beat && fill_q == CntW'(1)) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_FILL:  in_stall  = 1'b0;
			ST_DRAIN: out_valid = 1'b1;
			default: begin
				in_stall  = 1'b1;
				out_valid = 1'b0;
			end
		endcase
	end

	assign ctl.ins   = in_beat && !full;
	assign ctl.drain = out_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			fill_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_beat) begin
				fill_q <= fill_q - CntW'(1);
				if (fill_q == CntW'(1)) begin
					dropped_q <= 1'b0;
				end
			end else if (in_beat) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CntW'(1);
				end
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occ;
		logic lgt;
		rec_t lrec, rrec;

		assign occ = (CntW'(i) < fill_q);
		if (i == 0) begin : g_first
			assign lgt  = 1'b0;
			assign lrec = new_rec;
		end else begin : g_mid
			assign lgt  = gt[i-1];
			assign lrec = recs[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign rrec = recs[i];
		end else begin : g_inner
			assign rrec = recs[i+1];
		end

		krs_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ),
			.new_rec   (new_rec),
			.new_ok    (new_ok),
			.left_gt   (lgt),
			.left_rec  (lrec),
			.right_rec (rrec),
			.gt        (gt[i]),
			.rec       (recs[i])
		);
	end

	assign out_key_x     = recs[0].key;
	assign out_coord_y   = recs[0].y;
	assign out_coord_z   = recs[0].z;
	assign out_record_id = recs[0].id;
	assign out_last      = (fill_q == CntW'(1));
	assign overflow      = dropped_q;

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_q != '0)
		else $error("drain with an empty chain");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && last_item |=> out_valid)
		else $error("run end did not start the drain");

	a_drain_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_last |=> fill_q == '0 && !dropped_q && !out_valid)
		else $error("state not cleared after the final beat");

	a_full_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && full |=> dropped_q)
		else $error("dropped beat not flagged");

endmodule

@@ tb/keyed_record_sorter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_record_sorter_unit_tb
// Self-checking testbench for the keyed record sorter. Runs of records are
// sent through the input channel, and an independent sorting predictor works
// out the sorted run expected on the output channel. This includes stable
// order for equal keys, signed zeros comparing equal, and the overflow flag
// on runs longer than the store. A short directed table comes first. Random
// runs follow in three idling patterns with one receiver hold-off in each.
// ----------------------------------------------------------------------------
module keyed_record_sorter_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import krs_pkg::*;

	localparam int unsigned CAP = 64;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned DRAIN_SLACK = 8;
	localparam longint unsigned CYCLE_LIMIT = 300000;

	typedef enum int {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_FULL_RATE
	} phase_t;

	typedef struct {
		rec_t   rec;
		logic   last;
		logic   lit;
		phase_t phase;
	} beat_t;

	typedef struct {
		rec_t rec;
		logic last;
		logic ovf;
	} sorted_beat_t;

	typedef struct packed {
		logic [FieldW-1:0] key;
		logic [FieldW-1:0] y;
		logic [FieldW-1:0] z;
		logic [FieldW-1:0] id;
		logic              last;
		logic              lit;
	} dir_row_t;

	localparam dir_row_t DIRECTED [20] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
		'{32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0001, 1'b1, 1'b1},
		'{32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0010, 1'b0, 1'b0},
		'{32'h8000_0000, 32'hBF80_0000, 32'hFFFF_FFFF, 32'h0000_0011, 1'b0, 1'b0},
		'{32'h0000_0000, 32'h0000_0000, 32'h7F80_0000, 32'h0000_0012, 1'b0, 1'b0},
		'{32'hBF80_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0013, 1'b1, 1'b0},
		'{32'h7F80_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0020, 1'b0, 1'b0},
		'{32'hFF80_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0021, 1'b0, 1'b0},
		'{32'h3F80_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0022, 1'b0, 1'b0},
		'{32'hBF80_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0023, 1'b0, 1'b0},
		'{32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 32'h0000_0024, 1'b0, 1'b0},
		'{32'h8000_0001, 32'h8000_0000, 32'h0000_0001, 32'h0000_0025, 1'b0, 1'b0},
		'{32'h7F7F_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{32'hFF7F_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0},
		'{32'h4000_0000, 32'h0000_0030, 32'h0000_0030, 32'h0000_0030, 1'b0, 1'b0},
		'{32'h4000_0000, 32'h0000_0031, 32'h0000_0031, 32'h0000_0031, 1'b0, 1'b0},
		'{32'h3F00_0000, 32'h0000_0032, 32'h0000_0032, 32'h0000_0032, 1'b0, 1'b0},
		'{32'h4000_0000, 32'h0000_0033, 32'h0000_0033, 32'h0000_0033, 1'b0, 1'b0},
		'{32'hC000_0000, 32'h0000_0034, 32'h0000_0034, 32'h0000_0034, 1'b1, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FieldW-1:0] key_x = '0;
	logic [FieldW-1:0] coord_y = '0;
	logic [FieldW-1:0] coord_z = '0;
	logic [FieldW-1:0] record_id = '0;
	logic              last_item = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [FieldW-1:0] out_key_x;
	logic [FieldW-1:0] out_coord_y;
	logic [FieldW-1:0] out_coord_z;
	logic [FieldW-1:0] out_record_id;
	logic              out_last;
	logic              overflow;

	beat_t          beat_queue [$];
	beat_t          cur_beat;
	rec_t           run_store [$];
	logic           run_dropped = 1'b0;
	sorted_beat_t   sorted_expect [$];
	phase_t         phase_now = PH_SLOW_SINK;
	phase_t         held_phase;
	logic           hold_done = 1'b0;
	int unsigned    hold_left = 0;
	logic           tx_enable = 1'b0;
	int unsigned    fail_count = 0;
	longint unsigned cycle_count = 0;

	keyed_record_sorter_unit #(
		.CAPACITY(CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_x        (key_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.record_id    (record_id),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_key_x    (out_key_x),
		.out_coord_y  (out_coord_y),
		.out_coord_z  (out_coord_z),
		.out_record_id(out_record_id),
		.out_last     (out_last),
		.overflow     (overflow)
	);

	always #5 clk = ~clk;

	function automatic int unsigned idle_pct(phase_t ph, bit receiver);
		case (ph)
			PH_SLOW_SINK: return receiver ? 75 : 31;
			PH_SLOW_SOURCE: return receiver ? 31 : 75;
			default: return 0;
		endcase
	endfunction

	function automatic logic [FieldW-1:0] float_rank(logic [FieldW-1:0] bits);
		if (bits == 32'h8000_0000) begin
			return 32'h8000_0000;
		end
		return bits[31] ? ~bits : {1'b1, bits[30:0]};
	endfunction

	function automatic logic [FieldW-1:0] random_key();
		logic [FieldW-1:0] k;
		k = $urandom;
		case ($urandom_range(0, 7))
			0: begin
			end
			1: begin
				case ($urandom_range(0, 7))
					0: k = 32'h0000_0000;
					1: k = 32'h8000_0000;
					2: k = 32'h7F80_0000;
					3: k = 32'hFF80_0000;
					4: k = 32'h7FC0_0000;
					5: k = 32'hFFC0_0000;
					6: k = 32'h0000_0001;
					default: k = 32'h8000_0001;
				endcase
			end
			2, 3: begin
				k = 32'h3F80_0000 | (32'($urandom_range(0, 3)) << 21);
				k[31] = 1'($urandom_range(0, 1));
			end
			default: begin
				k[30:23] = 8'($urandom_range(110, 140));
			end
		endcase
		return k;
	endfunction

	task automatic queue_run(int unsigned len, phase_t ph);
		beat_t b;
		for (int unsigned i = 0; i < len; i++) begin
			b.rec.key = random_key();
			b.rec.y = $urandom;
			b.rec.z = $urandom;
			b.rec.id = $urandom;
			b.last = (i + 1 == len);
			b.lit = 1'b0;
			b.phase = ph;
			beat_queue.push_back(b);
		end
	endtask

	task automatic sort_in_beat(beat_t b);
		sorted_beat_t s;
		int unsigned pos;
		if (b.lit) begin
			s.rec = b.rec;
			s.last = 1'b1;
			s.ovf = 1'b0;
			sorted_expect.push_back(s);
		end else begin
			if (run_store.size() < CAP) begin
				pos = run_store.size();
				for (int unsigned i = 0; i < run_store.size(); i++) begin
					if (float_rank(run_store[i].key) > float_rank(b.rec.key)) begin
						pos = i;
						break;
					end
				end
				run_store.insert(pos, b.rec);
			end else begin
				run_dropped = 1'b1;
			end
			if (b.last) begin
				for (int unsigned i = 0; i < run_store.size(); i++) begin
					s.rec = run_store[i];
					s.last = (i + 1 == run_store.size());
					s.ovf = run_dropped;
					sorted_expect.push_back(s);
				end
				run_store.delete();
				run_dropped = 1'b0;
			end
		end
	endtask

	task automatic check_field(string name, logic [FieldW-1:0] want, logic [FieldW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && tx_enable) begin
			if (in_valid && !in_stall) begin
				sort_in_beat(cur_beat);
			end
			if (!in_valid || !in_stall) begin
				if (beat_queue.size() != 0 && (hold_left != 0 ||
						$urandom_range(0, 99) >= idle_pct(beat_queue[0].phase, 1'b0))) begin
					cur_beat = beat_queue.pop_front();
					key_x <= cur_beat.rec.key;
					coord_y <= cur_beat.rec.y;
					coord_z <= cur_beat.rec.z;
					record_id <= cur_beat.rec.id;
					last_item <= cur_beat.last;
					phase_now <= cur_beat.phase;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (out_valid && sorted_expect.size() > 40 &&
					(!hold_done || held_phase != phase_now)) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				held_phase <= phase_now;
				hold_done <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < idle_pct(phase_now, 1'b1));
			end
		end
	end

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_expect.size() == 0) begin
				$display("%0t: unexpected output beat key %h id %h", $time, out_key_x,
					out_record_id);
				fail_count++;
			end else begin
				want = sorted_expect.pop_front();
				check_field("out_key_x", want.rec.key, out_key_x);
				check_field("out_coord_y", want.rec.y, out_coord_y);
				check_field("out_coord_z", want.rec.z, out_coord_z);
				check_field("out_record_id", want.rec.id, out_record_id);
				check_field("out_last", 32'(want.last), 32'(out_last));
				check_field("overflow", 32'(want.ovf), 32'(overflow));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("keyed_record_sorter_unit: mismatch");
			$finish;
		end
	end

	initial begin
		beat_t b;
		int unsigned placed;
		int unsigned len;
		for (int i = 0; i < 20; i++) begin
			b.rec.key = DIRECTED[i].key;
			b.rec.y = DIRECTED[i].y;
			b.rec.z = DIRECTED[i].z;
			b.rec.id = DIRECTED[i].id;
			b.last = DIRECTED[i].last;
			b.lit = DIRECTED[i].lit;
			b.phase = PH_SLOW_SINK;
			beat_queue.push_back(b);
		end
		for (int p = PH_SLOW_SINK; p <= PH_FULL_RATE; p++) begin
			placed = 0;
			len = (p == PH_SLOW_SINK) ? CAP : (p == PH_SLOW_SOURCE) ? CAP + 1 : CAP + 6;
			while (placed < PHASE_ITEMS) begin
				queue_run(len, phase_t'(p));
				placed += len;
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(CAP - 4, CAP + 8) :
					$urandom_range(1, 12);
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tx_enable <= 1'b1;
		@(posedge clk);
		while (beat_queue.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (sorted_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SLACK) @(posedge clk);
		if (fail_count == 0) begin
			$display("keyed_record_sorter_unit: match");
		end else begin
			$display("keyed_record_sorter_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ keyed_record_sorter_unit.f @@
sv/krs_pkg.sv
sv/krs_cell.sv
sv/keyed_record_sorter_unit.sv
tb/keyed_record_sorter_unit_tb.sv
